### design/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the sector cache tag directory: slot count,
// transaction payloads, the record that walks the cell chain and cell control.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int SLOTS       = 64;
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [SECTOR_BITS-1:0] sector_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    sector_t    sector;
  } req_t;

  typedef struct packed {
    slot_t   slot;
    logic    hit;
    logic    fill;
    logic    writeback;
    sector_t writeback_sector;
    logic    last;
  } rsp_t;

  // record handed from cell to cell, towards slot 0
  typedef struct packed {
    logic    act;
    logic    hit;
    slot_t   hit_idx;
    logic    emp;
    slot_t   emp_idx;
    logic    una;
    slot_t   una_idx;
    sector_t una_tag;
    logic    una_dirty;
    sector_t cur_tag;
    logic    cur_dirty;
  } rec_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOOK,
    OP_FLOAD,
    OP_FSHIFT,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t     op;
    sector_t sector;
    logic    write;
    logic    fill;
    slot_t   slot;
    logic    clr;
    logic    clr_all;
  } ctl_t;

endpackage

### design/sector_cache_clock_directory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_clock_directory
// Fully associative tag directory with clock replacement, built as a row of
// slot cells that hand a lookup or flush record down towards slot 0.
// ----------------------------------------------------------------------------
// read/write: the record walks all SLOTS cells, one per cycle, then a decide
//   step that waits for a free output; one request at a time
// flush: dirty slots shift down the chain, stalling on the output, one writeback per dirty slot
// reset (synchronous) clears every valid, accessed and dirty mark in one cycle
// ----------------------------------------------------------------------------
module sector_cache_clock_directory (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  scd_pkg::req_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output scd_pkg::rsp_t  rsp
);
  import scd_pkg::*;

  rec_t rec_q [SLOTS];
  rec_t inject;
  ctl_t ctl;

  scd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (rec_q[0]),
    .inject    (inject),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rec_t rec_in;
    if (i == SLOTS - 1) begin : g_top
      assign rec_in = inject;
    end else begin : g_mid
      assign rec_in = rec_q[i+1];
    end
    scd_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .idx    (SLOT_W'(i)),
      .ctl    (ctl),
      .rec_in (rec_in),
      .rec    (rec_q[i])
    );
  end

endmodule

### design/scd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_cell
// One directory slot: tag, valid, accessed and dirty, plus the chain stage
// that passes the lookup or flush record on to the next lower slot.
// ----------------------------------------------------------------------------
module scd_cell (
  input  logic          clk,
  input  logic          rst,
  input  scd_pkg::slot_t idx,
  input  scd_pkg::ctl_t  ctl,
  input  scd_pkg::rec_t  rec_in,
  output scd_pkg::rec_t  rec
);
  import scd_pkg::*;

  sector_t tag;
  logic    valid;
  logic    accessed;
  logic    dirty;
  rec_t    look_rec;
  rec_t    load_rec;
  logic    sel;

  always_comb begin
    look_rec = rec_in;
    if (valid && (tag == ctl.sector)) begin
      look_rec.hit     = 1'b1;
      look_rec.hit_idx = idx;
    end
    if (!valid) begin
      look_rec.emp     = 1'b1;
      look_rec.emp_idx = idx;
    end
    if (valid && !accessed) begin
      look_rec.una       = 1'b1;
      look_rec.una_idx   = idx;
      look_rec.una_tag   = tag;
      look_rec.una_dirty = dirty;
    end
    look_rec.cur_tag   = tag;
    look_rec.cur_dirty = dirty;
  end

  always_comb begin
    load_rec         = '0;
    load_rec.act     = valid && dirty;
    load_rec.hit_idx = idx;
    load_rec.cur_tag = tag;
  end

  assign sel = (idx == ctl.slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      accessed <= 1'b0;
      dirty    <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_FLOAD: begin
          dirty <= 1'b0;
        end
        OP_UPDATE: begin
          if (sel) begin
            accessed <= 1'b1;
            if (ctl.fill) begin
              valid <= 1'b1;
              dirty <= ctl.write;
            end else if (ctl.write) begin
              dirty <= 1'b1;
            end
          end else if (ctl.clr && (ctl.clr_all || (idx < ctl.slot))) begin
            accessed <= 1'b0;
          end
        end
        OP_HOLD, OP_LOOK, OP_FSHIFT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == OP_UPDATE) && sel && ctl.fill) begin
      tag <= ctl.sector;
    end
    unique case (ctl.op)
      OP_LOOK:   rec <= look_rec;
      OP_FSHIFT: rec <= rec_in;
      OP_FLOAD:  rec <= load_rec;
      OP_HOLD, OP_UPDATE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### design/scd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_ctrl
// Sequencer of the directory: takes requests, walks the record down the cell
// chain, decides hit, fill or clock victim, and streams flush writebacks.
// ----------------------------------------------------------------------------
module scd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  scd_pkg::req_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output scd_pkg::rsp_t  rsp,
  input  scd_pkg::rec_t  head,
  output scd_pkg::rec_t  inject,
  output scd_pkg::ctl_t  ctl
);
  import scd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_FLOAD,
    S_FSHIFT,
    S_FDRAIN
  } state_t;

  state_t  state;
  slot_t   cnt;
  sector_t sector;
  logic    wr;
  logic    pend_v;
  slot_t   pend_slot;
  sector_t pend_tag;

  logic    out_free;
  logic    shift_ok;
  logic    scan;
  logic    wb;
  slot_t   dec_slot;
  sector_t wb_sector;
  logic    rsp_valid_next;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign shift_ok  = !(head.act && pend_v && !out_free);

  always_comb begin
    inject     = '0;
    inject.act = (state == S_LOOK);
  end

  always_comb begin
    scan = !head.hit && !head.emp;
    if (head.hit) begin
      dec_slot = head.hit_idx;
    end else if (head.emp) begin
      dec_slot = head.emp_idx;
    end else if (head.una) begin
      dec_slot = head.una_idx;
    end else begin
      dec_slot = '0;
    end
    wb        = scan && (head.una ? head.una_dirty : head.cur_dirty);
    wb_sector = wb ? (head.una ? head.una_tag : head.cur_tag) : '0;
  end

  always_comb begin
    ctl.sector  = sector;
    ctl.write   = wr;
    ctl.fill    = !head.hit;
    ctl.slot    = dec_slot;
    ctl.clr     = scan;
    ctl.clr_all = scan && !head.una;
    unique case (state)
      S_LOOK:   ctl.op = OP_LOOK;
      S_UPD:    ctl.op = out_free ? OP_UPDATE : OP_HOLD;
      S_FLOAD:  ctl.op = OP_FLOAD;
      S_FSHIFT: ctl.op = shift_ok ? OP_FSHIFT : OP_HOLD;
      S_IDLE, S_FDRAIN: ctl.op = OP_HOLD;
      default:  ctl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_UPD: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
        end
      end
      S_FSHIFT: begin
        if (shift_ok && head.act && pend_v) begin
          rsp_valid_next = 1'b1;
        end
      end
      S_FDRAIN: begin
        if (pend_v && out_free) begin
          rsp_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
      cnt       <= '0;
    end else begin
      rsp_valid <= rsp_valid_next;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            sector <= req.sector;
            wr     <= (req.command == CMD_WRITE);
            cnt    <= '0;
            unique case (req.command)
              CMD_READ, CMD_WRITE: state <= S_LOOK;
              CMD_FLUSH:           state <= S_FLOAD;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_LOOK: begin
          cnt <= cnt + 1'b1;
          if (cnt == SLOT_W'(SLOTS - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            rsp.slot             <= dec_slot;
            rsp.hit              <= head.hit;
            rsp.fill             <= !head.hit;
            rsp.writeback        <= wb;
            rsp.writeback_sector <= wb_sector;
            rsp.last             <= 1'b1;
            state                <= S_IDLE;
          end
        end
        S_FLOAD: begin
          cnt    <= '0;
          pend_v <= 1'b0;
          state  <= S_FSHIFT;
        end
        S_FSHIFT: begin
          if (shift_ok) begin
            cnt <= cnt + 1'b1;
            if (head.act) begin
              if (pend_v) begin
                rsp.slot             <= pend_slot;
                rsp.hit              <= 1'b0;
                rsp.fill             <= 1'b0;
                rsp.writeback        <= 1'b1;
                rsp.writeback_sector <= pend_tag;
                rsp.last             <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_slot <= head.hit_idx;
              pend_tag  <= head.cur_tag;
            end
            if (cnt == SLOT_W'(SLOTS - 1)) begin
              state <= S_FDRAIN;
            end
          end
        end
        S_FDRAIN: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            rsp.slot             <= pend_slot;
            rsp.hit              <= 1'b0;
            rsp.fill             <= 1'b0;
            rsp.writeback        <= 1'b1;
            rsp.writeback_sector <= pend_tag;
            rsp.last             <= 1'b1;
            pend_v               <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
